// ===== src/esbt_pkg.sv =====
`default_nettype none

package esbt_pkg;

    // widths of the timing fields
    localparam int unsigned TimeW  = 12;
    localparam int unsigned AddrW  = 8;
    localparam int unsigned PhaseW = 4;

    typedef logic [PhaseW-1:0] t_phase;
    typedef logic [TimeW-1:0]  t_ticks;

    // sequence phases
    localparam t_phase PhIdle      = 4'd0;
    localparam t_phase PhFirstLow  = 4'd1;
    localparam t_phase PhDetHigh   = 4'd2;
    localparam t_phase PhDetLow    = 4'd3;
    localparam t_phase PhWindow    = 4'd4;
    localparam t_phase PhStartA    = 4'd5;
    localparam t_phase PhBitLowA   = 4'd6;
    localparam t_phase PhBitHighA  = 4'd7;
    localparam t_phase PhEosA      = 4'd8;
    localparam t_phase PhStartD    = 4'd9;
    localparam t_phase PhBitLowD   = 4'd10;
    localparam t_phase PhBitHighD  = 4'd11;
    localparam t_phase PhEosD      = 4'd12;

    // input item kinds
    localparam logic [1:0] KindTick    = 2'd0;
    localparam logic [1:0] KindUpdate  = 2'd1;
    localparam logic [1:0] KindSuspend = 2'd2;
    localparam logic [1:0] KindResume  = 2'd3;

    // register indexes
    localparam logic [2:0] RegShortTime    = 3'd0;
    localparam logic [2:0] RegLongTime     = 3'd1;
    localparam logic [2:0] RegStartEosTime = 3'd2;
    localparam logic [2:0] RegDetectDelay  = 3'd3;
    localparam logic [2:0] RegDetectTime   = 3'd4;
    localparam logic [2:0] RegDetectWindow = 3'd5;
    localparam logic [2:0] RegDeviceAddr   = 3'd6;
    localparam logic [2:0] RegFirstLowTime = 3'd7;

    // register reset values
    localparam t_ticks           ShortTimeRst    = 12'd15;
    localparam t_ticks           LongTimeRst     = 12'd50;
    localparam t_ticks           StartEosTimeRst = 12'd10;
    localparam t_ticks           DetectDelayRst  = 12'd120;
    localparam t_ticks           DetectTimeRst   = 12'd300;
    localparam t_ticks           DetectWindowRst = 12'd1000;
    localparam logic [AddrW-1:0] DeviceAddrRst   = 8'h72;
    localparam t_ticks           FirstLowTimeRst = 12'd4000;

    // brightness ceiling of the data byte
    localparam logic [7:0] BrightMax = 8'd31;

    // a programmed duration of zero counts as one tick
    function automatic t_ticks dur(input t_ticks v);
        dur = (v == '0) ? t_ticks'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== src/easyscale_backlight_transmitter.sv =====
`default_nettype none

// the result of each accepted input transaction is registered and appears on the master side in the next cycle
// throughput: one input transaction per cycle while the result side takes results; the whole step is one decrement and
// compare of the phase counter plus the phase selection, between input and result register
// the output register frees in the same cycle it is taken, so back pressure costs nothing extra
// reset: synchronous, active low; registers return to their defaults, pin high, idle

module easyscale_backlight_transmitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] brightness, [8] display_on, rest zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] pin_level, [1] busy_res, [2] frame_done
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    // configuration registers
    esbt_pkg::t_ticks r_short_time, r_long_time, r_start_eos_time, r_detect_delay;
    esbt_pkg::t_ticks r_detect_time, r_detect_window, r_first_low_time;
    logic [esbt_pkg::AddrW-1:0] r_device_addr;

    // sequencer state
    esbt_pkg::t_phase r_phase, n_phase;
    esbt_pkg::t_ticks r_time_left, n_time_left;
    logic [2:0]       r_bit_index, n_bit_index;
    logic [7:0]       r_shift_byte, n_shift_byte;
    logic [4:0]       r_data_byte, n_data_byte;
    logic             r_mode_entered, n_mode_entered;
    logic             r_suspended, n_suspended;
    logic             r_first_update, n_first_update;
    logic             r_pin, n_pin;
    logic             n_done;

    // result register
    logic             r_out_valid;
    logic [2:0]       r_out;

    logic             in_fire;
    logic [1:0]       in_kind;
    logic [7:0]       in_bright;
    logic             in_on;

    assign in_kind       = s_axis_tuser;
    assign in_bright     = s_axis_tdata[7:0];
    assign in_on         = s_axis_tdata[8];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_time     <= esbt_pkg::ShortTimeRst;
            r_long_time      <= esbt_pkg::LongTimeRst;
            r_start_eos_time <= esbt_pkg::StartEosTimeRst;
            r_detect_delay   <= esbt_pkg::DetectDelayRst;
            r_detect_time    <= esbt_pkg::DetectTimeRst;
            r_detect_window  <= esbt_pkg::DetectWindowRst;
            r_device_addr    <= esbt_pkg::DeviceAddrRst;
            r_first_low_time <= esbt_pkg::FirstLowTimeRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                esbt_pkg::RegShortTime:    r_short_time     <= i_cfg_data;
                esbt_pkg::RegLongTime:     r_long_time      <= i_cfg_data;
                esbt_pkg::RegStartEosTime: r_start_eos_time <= i_cfg_data;
                esbt_pkg::RegDetectDelay:  r_detect_delay   <= i_cfg_data;
                esbt_pkg::RegDetectTime:   r_detect_time    <= i_cfg_data;
                esbt_pkg::RegDetectWindow: r_detect_window  <= i_cfg_data;
                esbt_pkg::RegDeviceAddr:   r_device_addr    <= i_cfg_data[esbt_pkg::AddrW-1:0];
                esbt_pkg::RegFirstLowTime: r_first_low_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state for one input transaction
    always_comb begin
        logic             busy;
        logic             second;
        logic             bit_val;
        logic [2:0]       idx;
        esbt_pkg::t_ticks dec;
        logic [7:0]       b;

        n_phase        = r_phase;
        n_time_left    = r_time_left;
        n_bit_index    = r_bit_index;
        n_shift_byte   = r_shift_byte;
        n_data_byte    = r_data_byte;
        n_mode_entered = r_mode_entered;
        n_suspended    = r_suspended;
        n_first_update = r_first_update;
        n_pin          = r_pin;
        n_done         = 1'b0;

        busy    = (r_phase >= esbt_pkg::PhFirstLow) && (r_phase <= esbt_pkg::PhEosD);
        second  = (r_phase >= esbt_pkg::PhStartD);
        dec     = r_time_left - esbt_pkg::t_ticks'(1);
        idx     = (r_phase == esbt_pkg::PhBitHighA || r_phase == esbt_pkg::PhBitHighD)
                  ? r_bit_index - 3'd1 : r_bit_index;
        bit_val = r_shift_byte[idx];
        b       = in_on ? in_bright : 8'd0;
        if (b > esbt_pkg::BrightMax) begin
            b = esbt_pkg::BrightMax;
        end

        // unused phase codes fall back to idle
        if (!busy) begin
            n_phase     = esbt_pkg::PhIdle;
            n_time_left = '0;
        end

        if (in_kind == esbt_pkg::KindTick) begin
            if (busy) begin
                n_time_left = dec;
                if (dec == '0) begin
                    // phase ends: step the sequence
                    unique case (r_phase)
                        esbt_pkg::PhFirstLow: begin
                            n_pin = 1'b1;
                            if (!r_mode_entered) begin
                                n_phase     = esbt_pkg::PhDetHigh;
                                n_time_left = esbt_pkg::dur(r_detect_delay);
                            end else begin
                                n_phase     = esbt_pkg::PhWindow;
                                n_time_left = esbt_pkg::dur(r_detect_window);
                            end
                        end
                        esbt_pkg::PhDetHigh: begin
                            n_phase     = esbt_pkg::PhDetLow;
                            n_pin       = 1'b0;
                            n_time_left = esbt_pkg::dur(r_detect_time);
                        end
                        esbt_pkg::PhDetLow: begin
                            n_mode_entered = 1'b1;
                            n_phase        = esbt_pkg::PhWindow;
                            n_pin          = 1'b1;
                            n_time_left    = esbt_pkg::dur(r_detect_window);
                        end
                        esbt_pkg::PhWindow: begin
                            n_shift_byte = r_device_addr;
                            n_bit_index  = 3'd7;
                            n_phase      = esbt_pkg::PhStartA;
                            n_pin        = 1'b1;
                            n_time_left  = esbt_pkg::dur(r_start_eos_time);
                        end
                        esbt_pkg::PhStartA, esbt_pkg::PhStartD: begin
                            n_phase     = second ? esbt_pkg::PhBitLowD : esbt_pkg::PhBitLowA;
                            n_pin       = 1'b0;
                            n_time_left = esbt_pkg::dur(bit_val ? r_short_time : r_long_time);
                        end
                        esbt_pkg::PhBitLowA, esbt_pkg::PhBitLowD: begin
                            n_phase     = second ? esbt_pkg::PhBitHighD : esbt_pkg::PhBitHighA;
                            n_pin       = 1'b1;
                            n_time_left = esbt_pkg::dur(bit_val ? r_long_time : r_short_time);
                        end
                        esbt_pkg::PhBitHighA, esbt_pkg::PhBitHighD: begin
                            n_pin = 1'b0;
                            if (r_bit_index == 3'd0) begin
                                n_phase     = second ? esbt_pkg::PhEosD : esbt_pkg::PhEosA;
                                n_time_left = esbt_pkg::dur(r_start_eos_time);
                            end else begin
                                n_bit_index = idx;
                                n_phase     = second ? esbt_pkg::PhBitLowD
                                                     : esbt_pkg::PhBitLowA;
                                n_time_left = esbt_pkg::dur(bit_val ? r_short_time
                                                                    : r_long_time);
                            end
                        end
                        esbt_pkg::PhEosA: begin
                            n_shift_byte = {3'd0, r_data_byte};
                            n_bit_index  = 3'd7;
                            n_phase      = esbt_pkg::PhStartD;
                            n_pin        = 1'b1;
                            n_time_left  = esbt_pkg::dur(r_start_eos_time);
                        end
                        esbt_pkg::PhEosD: begin
                            n_phase     = esbt_pkg::PhIdle;
                            n_time_left = '0;
                            n_bit_index = 3'd7;
                            n_pin       = 1'b1;
                            n_done      = 1'b1;
                        end
                        default: begin
                            n_phase     = esbt_pkg::PhIdle;
                            n_time_left = '0;
                        end
                    endcase
                end
            end
        end else if (!busy) begin
            unique case (in_kind)
                esbt_pkg::KindUpdate: begin
                    if (!r_suspended) begin
                        n_data_byte = b[4:0];
                        if (r_first_update) begin
                            n_first_update = 1'b0;
                            n_phase        = esbt_pkg::PhFirstLow;
                            n_pin          = 1'b0;
                            n_time_left    = esbt_pkg::dur(r_first_low_time);
                        end else if (!r_mode_entered) begin
                            n_phase     = esbt_pkg::PhDetHigh;
                            n_pin       = 1'b1;
                            n_time_left = esbt_pkg::dur(r_detect_delay);
                        end else begin
                            n_phase     = esbt_pkg::PhWindow;
                            n_pin       = 1'b1;
                            n_time_left = esbt_pkg::dur(r_detect_window);
                        end
                    end
                end
                esbt_pkg::KindSuspend: begin
                    n_pin       = 1'b0;
                    n_suspended = 1'b1;
                end
                esbt_pkg::KindResume: begin
                    n_mode_entered = 1'b0;
                    n_first_update = 1'b0;
                    n_suspended    = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= esbt_pkg::PhIdle;
            r_time_left    <= '0;
            r_bit_index    <= 3'd7;
            r_shift_byte   <= '0;
            r_data_byte    <= '0;
            r_mode_entered <= 1'b0;
            r_suspended    <= 1'b0;
            r_first_update <= 1'b1;
            r_pin          <= 1'b1;
        end else if (in_fire) begin
            r_phase        <= n_phase;
            r_time_left    <= n_time_left;
            r_bit_index    <= n_bit_index;
            r_shift_byte   <= n_shift_byte;
            r_data_byte    <= n_data_byte;
            r_mode_entered <= n_mode_entered;
            r_suspended    <= n_suspended;
            r_first_update <= n_first_update;
            r_pin          <= n_pin;
        end
    end

    // result register, refilled in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= {n_done, (n_phase != esbt_pkg::PhIdle), n_pin};
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/esbt_tb_pkg.sv =====
package esbt_tb_pkg;

    import esbt_pkg::*;

    // one result of the transmitter, as the predictor expects it
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } t_pin_result;

    // predicts the pin waveform tick by tick and checks the result stream
    class pin_wave_scoreboard;

        // timing and address registers
        t_ticks      short_t;
        t_ticks      long_t;
        t_ticks      eos_t;
        t_ticks      det_delay_t;
        t_ticks      det_low_t;
        t_ticks      window_t;
        t_ticks      first_low_t;
        logic [7:0]  dev_addr;

        // sequencer state
        t_phase      phase;
        t_ticks      ticks_left;
        logic [2:0]  bit_idx;
        logic [7:0]  shifter;
        logic [4:0]  level_code;
        bit          mode_on;
        bit          parked;
        bit          first_pending;
        bit          pin_high;

        t_pin_result expected_pins[$];
        int          fail_count;

        function new();
            short_t       = ShortTimeRst;
            long_t        = LongTimeRst;
            eos_t         = StartEosTimeRst;
            det_delay_t   = DetectDelayRst;
            det_low_t     = DetectTimeRst;
            window_t      = DetectWindowRst;
            dev_addr      = DeviceAddrRst;
            first_low_t   = FirstLowTimeRst;
            phase         = PhIdle;
            ticks_left    = '0;
            bit_idx       = 3'd7;
            shifter       = '0;
            level_code    = '0;
            mode_on       = 1'b0;
            parked        = 1'b0;
            first_pending = 1'b1;
            pin_high      = 1'b1;
            fail_count    = 0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [11:0] val);
            case (idx)
                RegShortTime:    short_t     = val;
                RegLongTime:     long_t      = val;
                RegStartEosTime: eos_t       = val;
                RegDetectDelay:  det_delay_t = val;
                RegDetectTime:   det_low_t   = val;
                RegDetectWindow: window_t    = val;
                RegDeviceAddr:   dev_addr    = val[7:0];
                default:         first_low_t = val;
            endcase
        endfunction

        function bit in_progress();
            return (phase >= PhFirstLow) && (phase <= PhEosD);
        endfunction

        function int outstanding();
            return expected_pins.size();
        endfunction

        // true when the block would drop this kind of transaction as it stands
        function bit is_ignored(input logic [1:0] kind);
            if (kind == KindTick)
                return !in_progress();
            return in_progress() || (kind == KindUpdate && parked);
        endfunction

        // a duration of zero still lasts one tick
        function void enter_phase(input t_phase ph, input bit lvl, input t_ticks n);
            phase      = ph;
            pin_high   = lvl;
            ticks_left = (n == '0) ? t_ticks'(1) : n;
        endfunction

        function void enter_bit_low(input bit data_half);
            enter_phase(data_half ? PhBitLowD : PhBitLowA, 1'b0,
                        shifter[bit_idx] ? short_t : long_t);
        endfunction

        // move to the next phase once the counter runs out; true at end of frame
        function bit next_phase();
            bit data_half;
            data_half = (phase >= PhStartD);
            case (phase)
                PhFirstLow: begin
                    if (!mode_on)
                        enter_phase(PhDetHigh, 1'b1, det_delay_t);
                    else
                        enter_phase(PhWindow, 1'b1, window_t);
                end
                PhDetHigh: enter_phase(PhDetLow, 1'b0, det_low_t);
                PhDetLow: begin
                    mode_on = 1'b1;
                    enter_phase(PhWindow, 1'b1, window_t);
                end
                PhWindow: begin
                    shifter = dev_addr;
                    bit_idx = 3'd7;
                    enter_phase(PhStartA, 1'b1, eos_t);
                end
                PhStartA, PhStartD: enter_bit_low(data_half);
                PhBitLowA, PhBitLowD: begin
                    enter_phase(data_half ? PhBitHighD : PhBitHighA, 1'b1,
                                shifter[bit_idx] ? long_t : short_t);
                end
                PhBitHighA, PhBitHighD: begin
                    if (bit_idx == 3'd0) begin
                        enter_phase(data_half ? PhEosD : PhEosA, 1'b0, eos_t);
                    end else begin
                        bit_idx = bit_idx - 3'd1;
                        enter_bit_low(data_half);
                    end
                end
                PhEosA: begin
                    shifter = {3'b000, level_code};
                    bit_idx = 3'd7;
                    enter_phase(PhStartD, 1'b1, eos_t);
                end
                PhEosD: begin
                    phase      = PhIdle;
                    ticks_left = '0;
                    bit_idx    = 3'd7;
                    pin_high   = 1'b1;
                    return 1'b1;
                end
                default: begin
                    phase      = PhIdle;
                    ticks_left = '0;
                end
            endcase
            return 1'b0;
        endfunction

        // apply one accepted input transaction and queue its result
        function void note_request(input logic [1:0] kind, input logic [7:0] bright,
                                   input logic on);
            bit          busy;
            bit          done;
            logic [7:0]  lvl;
            t_pin_result r;
            busy = in_progress();
            done = 1'b0;
            if (!busy && phase != PhIdle) begin
                phase      = PhIdle;
                ticks_left = '0;
            end
            if (kind == KindTick) begin
                if (busy) begin
                    ticks_left = ticks_left - t_ticks'(1);
                    if (ticks_left == '0)
                        done = next_phase();
                end
            end else if (!busy) begin
                case (kind)
                    KindUpdate: begin
                        if (!parked) begin
                            lvl = on ? bright : 8'd0;
                            if (lvl > BrightMax)
                                lvl = BrightMax;
                            level_code = lvl[4:0];
                            if (first_pending) begin
                                first_pending = 1'b0;
                                enter_phase(PhFirstLow, 1'b0, first_low_t);
                            end else if (!mode_on) begin
                                enter_phase(PhDetHigh, 1'b1, det_delay_t);
                            end else begin
                                enter_phase(PhWindow, 1'b1, window_t);
                            end
                        end
                    end
                    KindSuspend: begin
                        pin_high = 1'b0;
                        parked   = 1'b1;
                    end
                    default: begin
                        mode_on       = 1'b0;
                        first_pending = 1'b0;
                        parked        = 1'b0;
                    end
                endcase
            end
            r.pin_level  = pin_high;
            r.busy_res   = (phase != PhIdle);
            r.frame_done = done;
            expected_pins.push_back(r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_pin_result(input logic [7:0] data);
            t_pin_result want;
            if (expected_pins.size() == 0) begin
                $error("result with nothing expected: tdata %02h", data);
                fail_count++;
                return;
            end
            want = expected_pins.pop_front();
            if (data[0] !== want.pin_level) begin
                $error("pin_level: expected %0b, actual %0b", want.pin_level, data[0]);
                fail_count++;
            end
            if (data[1] !== want.busy_res) begin
                $error("busy_res: expected %0b, actual %0b", want.busy_res, data[1]);
                fail_count++;
            end
            if (data[2] !== want.frame_done) begin
                $error("frame_done: expected %0b, actual %0b", want.frame_done, data[2]);
                fail_count++;
            end
        endfunction

        function void close_out();
            if (expected_pins.size() != 0) begin
                $error("%0d results never arrived", expected_pins.size());
                fail_count++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import esbt_pkg::*;
    import esbt_tb_pkg::*;

    localparam int ClkPeriod   = 20;
    localparam int ResetCycles = 8;
    localparam int WatchLimit  = 2000;
    localparam int BurstItems  = 250;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    pin_wave_scoreboard sb;
    bit                 calm;
    int                 stall_left;
    int                 quiet_cycles;

    easyscale_backlight_transmitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back pressure
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else begin
                stall_left = pick_gap();
                m_axis_tready = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pin_result(m_axis_tdata);
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if (((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
             (i_cfg_valid && o_cfg_ready)) === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("easyscale_backlight_transmitter verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transaction, after a random gap
    task automatic push_item(input logic [1:0] kind, input logic [7:0] bright,
                             input logic on);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = kind;
        s_axis_tdata  = {7'd0, on, bright};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, bright, on);
    endtask

    task automatic push_kind(input logic [1:0] kind);
        logic [7:0] bright;
        logic       on;
        bright = 8'($urandom_range(0, 255));
        on     = 1'($urandom_range(0, 1));
        push_item(kind, bright, on);
    endtask

    // ticks until the current sequence is over
    task automatic finish_frame();
        while (sb.in_progress())
            push_kind(KindTick);
    endtask

    // hold the sender until every expected result is in
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input logic [11:0] short_v, input logic [11:0] long_v,
                                 input logic [11:0] eos_v, input logic [11:0] delay_v,
                                 input logic [11:0] det_v, input logic [11:0] window_v,
                                 input logic [11:0] addr_v, input logic [11:0] first_v);
        drain_results();
        write_reg(RegShortTime, short_v);
        write_reg(RegLongTime, long_v);
        write_reg(RegStartEosTime, eos_v);
        write_reg(RegDetectDelay, delay_v);
        write_reg(RegDetectTime, det_v);
        write_reg(RegDetectWindow, window_v);
        write_reg(RegDeviceAddr, addr_v);
        write_reg(RegFirstLowTime, first_v);
    endtask

    // short random timings so that many frames fit in a burst
    task automatic load_random_settings();
        load_settings(12'($urandom_range(0, 3)), 12'($urandom_range(0, 3)),
                      12'($urandom_range(0, 3)), 12'($urandom_range(0, 3)),
                      12'($urandom_range(0, 3)), 12'($urandom_range(0, 3)),
                      12'($urandom_range(0, 4095)), 12'($urandom_range(0, 3)));
    endtask

    // mostly ticks through frames and updates when idle, the rest suspends, resumes and dropped requests
    task automatic random_burst(input int n);
        int         counted;
        int         r;
        logic [1:0] kind;
        counted = 0;
        while (counted < n) begin
            r = $urandom_range(0, 99);
            if (sb.in_progress()) begin
                if (r < 94)
                    kind = KindTick;
                else
                    kind = 2'($urandom_range(1, 3));
            end else if (r < 70) begin
                kind = KindUpdate;
            end else if (r < 78) begin
                kind = KindSuspend;
            end else if (r < 90) begin
                kind = KindResume;
            end else begin
                kind = KindTick;
            end
            if (!sb.is_ignored(kind))
                counted++;
            push_kind(kind);
            if ($urandom_range(0, 299) == 0)
                drain_results();
        end
    endtask

    // main sequence
    initial begin
        sb            = new();
        calm          = 1'b0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KindTick;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = RegShortTime;
        i_cfg_data    = '0;
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n = 1'b1;

        // long first low hold, zero start/eos time, full address
        load_settings(12'd1, 12'd2, 12'd0, 12'd1, 12'd2, 12'd1, 12'h0FF, 12'd32);

        // directed: idle tick, first update, requests while busy
        push_item(KindTick, 8'h00, 1'b0);
        push_item(KindUpdate, 8'hFF, 1'b1);
        push_item(KindUpdate, 8'h00, 1'b0);
        push_item(KindSuspend, 8'hAA, 1'b1);
        push_item(KindResume, 8'h55, 1'b0);
        finish_frame();
        // saturation, exact ceiling, display off
        push_item(KindUpdate, 8'h20, 1'b1);
        finish_frame();
        push_item(KindUpdate, 8'd31, 1'b1);
        finish_frame();
        push_item(KindUpdate, 8'hFF, 1'b0);
        finish_frame();
        // suspend drops updates, resume re-runs the mode detect
        push_item(KindSuspend, 8'h55, 1'b1);
        push_item(KindUpdate, 8'h0A, 1'b1);
        push_item(KindTick, 8'h00, 1'b0);
        push_item(KindSuspend, 8'h00, 1'b0);
        push_item(KindResume, 8'hFF, 1'b1);
        push_item(KindUpdate, 8'h15, 1'b1);
        finish_frame();
        push_item(KindResume, 8'h01, 1'b0);
        push_item(KindUpdate, 8'h00, 1'b1);
        finish_frame();

        // random traffic under several timings
        load_random_settings();
        random_burst(BurstItems);
        load_settings(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'h000, 12'd1);
        random_burst(BurstItems);

        // long detect, window and framing times, without gaps
        calm = 1'b1;
        finish_frame();
        load_settings(12'd1, 12'd0, 12'd30, 12'd30, 12'd30, 12'd30, 12'hA5A, 12'd1);
        push_kind(KindResume);
        push_item(KindUpdate, 8'h1E, 1'b1);
        finish_frame();
        // long bit phase
        load_settings(12'd24, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'h3C3, 12'd0);
        push_item(KindUpdate, 8'h07, 1'b1);
        finish_frame();
        calm = 1'b0;

        load_random_settings();
        random_burst(BurstItems);
        load_random_settings();
        random_burst(BurstItems);

        drain_results();
        repeat (4) @(posedge i_clk);
        sb.close_out();
        if (sb.fail_count == 0)
            $display("easyscale_backlight_transmitter verification clean");
        else
            $display("easyscale_backlight_transmitter verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/esbt_pkg.sv
src/easyscale_backlight_transmitter.sv
tb/sv/esbt_tb_pkg.sv
tb/sv/tb_top.sv
